[rtl/core/mapc_pkg.sv]
`default_nettype none

package mapc_pkg;

  // Frame filter and sync pattern
  localparam logic [23:0] MCAST_PREFIX = 24'h01005E;
  localparam logic [15:0] LEN_LIMIT    = 16'd200;
  localparam logic [7:0]  SYNC_B3      = 8'h46;
  localparam logic [7:0]  SYNC_B4      = 8'h5A;
  localparam logic [8:0]  SYNC_STEP    = 9'd8;
  localparam logic [7:0]  CHECK_MASK   = 8'h7F;
  localparam logic [7:0]  CRC_POLY     = 8'h8C;

  // Collector mode, also the status code
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_LOCK = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  // One entry of the sync table
  typedef struct packed {
    logic [47:0] src;
    logic [7:0]  dlb;
    logic [7:0]  len;
  } slot_entry_t;

  // Controller to CRC engine: store write and scan start
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       start;
    logic [7:0] len;
  } crc_req_t;

  // CRC engine back to controller
  typedef struct packed {
    logic       done;
    logic [7:0] crc;
  } crc_rsp_t;

  // Reflected CRC-8, one byte folded in
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mapc_crc_engine.sv]
`default_nettype none

// Payload store with per-byte valid bits and a byte-serial CRC scan
module mapc_crc_engine #(
  parameter int PAYLOAD_MAX = 255
) (
  input  wire               clk,
  input  wire               rst,
  input  mapc_pkg::crc_req_t req,
  output mapc_pkg::crc_rsp_t rsp
);

  localparam int DEPTH = PAYLOAD_MAX + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]       store [DEPTH];
  logic [DEPTH-1:0] store_valid;

  logic             running;
  logic [7:0]       cnt;
  logic [7:0]       len_q;
  logic             rd_pend;
  logic             rd_ok;
  logic [7:0]       rd_data;
  logic [7:0]       crc;
  logic             done;

  logic             issue;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       rd_byte;

  assign issue   = running && (cnt < len_q);
  assign rd_addr = cnt[AW-1:0];
  assign wr_addr = req.waddr[AW-1:0];
  assign rd_byte = rd_ok ? rd_data : 8'h00;

  // Store array, write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      store[wr_addr] <= req.wdata;
    end
    if (issue) begin
      rd_data <= store[rd_addr];
    end
  end

  // Valid bits: unwritten bytes read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
      rd_ok       <= 1'b0;
    end else begin
      if (req.we) begin
        store_valid[wr_addr] <= 1'b1;
      end
      if (issue) begin
        rd_ok <= store_valid[rd_addr];
      end
    end
  end

  // Scan sequencer: one read issued and one byte folded per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      len_q   <= '0;
      rd_pend <= 1'b0;
      crc     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        len_q   <= req.len;
        rd_pend <= 1'b0;
        crc     <= '0;
      end else if (running) begin
        if (issue) begin
          cnt <= cnt + 8'd1;
        end
        rd_pend <= issue;
        if (rd_pend) begin
          crc <= mapc_pkg::crc_byte(crc, rd_byte);
        end
        if (!issue && !rd_pend) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.crc  = crc;

endmodule

`default_nettype wire

[rtl/core/multicast_addr_payload_collector_top.sv]
`default_nettype none

// Multicast address payload collector. A frame is taken when start is high and
// busy is low; its status appears on status for one cycle with status_valid high,
// and the receiver cannot stall it. Ignored frames, non-sync frames while waiting,
// locked frames that fail the check and frames after completion report in the
// next cycle. A sync frame while waiting walks the sync table, with a read state
// and a check state per slot through the table's read port, before it returns. A
// locked frame that passes the check writes two bytes and rescans the payload store
// one byte per cycle through the CRC engine. After reset the block is ready at once:
// empty table slots and unwritten payload bytes are tracked by valid bits.
module multicast_addr_payload_collector_top #(
  parameter int SLOT_COUNT  = 8,
  parameter int PAYLOAD_MAX = 255
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [47:0] source_address,
  input  wire  [47:0] dest_address,
  input  wire  [15:0] frame_length,
  output logic        status_valid,
  output logic [1:0]  status
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [8:0]    PMAX9     = 9'(PAYLOAD_MAX);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SLOT_RD  = 6'b000010,
    ST_SLOT_CHK = 6'b000100,
    ST_WR_LO    = 6'b001000,
    ST_WR_HI    = 6'b010000,
    ST_CRC_WAIT = 6'b100000
  } state_t;

  state_t                 state;
  logic [1:0]             mode;
  logic [SW-1:0]          next_slot;
  logic [SW-1:0]          scan_idx;
  logic [SLOT_COUNT-1:0]  slot_full;
  logic [7:0]             payload_length;
  logic [7:0]             base_length;
  logic [7:0]             expected_crc;
  logic [47:0]            src_q;
  logic [7:0]             len_q;
  logic [7:0]             b4_q;
  logic [7:0]             b5_q;
  logic [7:0]             off_q;

  mapc_pkg::slot_entry_t  slot_mem [SLOT_COUNT];
  mapc_pkg::slot_entry_t  slot_rd;
  mapc_pkg::slot_entry_t  slot_wd;
  logic                   slot_we;
  logic [SW-1:0]          slot_wa;

  mapc_pkg::crc_req_t     crc_req;
  mapc_pkg::crc_rsp_t     crc_rsp;

  // Input decode
  logic [7:0] in_b3, in_b4, in_b5, in_len;
  logic [7:0] in_sum;
  logic [7:0] lock_off;
  logic       ignore, is_sync, lock_ok, accept;

  assign accept   = start && !busy;
  assign in_b3    = dest_address[23:16];
  assign in_b4    = dest_address[15:8];
  assign in_b5    = dest_address[7:0];
  assign in_len   = frame_length[7:0];
  assign in_sum   = in_b4 + in_b5;
  assign lock_off = in_len - base_length;
  assign ignore   = (dest_address[47:24] != mapc_pkg::MCAST_PREFIX) ||
                    (frame_length > mapc_pkg::LEN_LIMIT);
  assign is_sync  = (in_b3 == mapc_pkg::SYNC_B3) && (in_b4 == mapc_pkg::SYNC_B4);
  assign lock_ok  = (in_len >= base_length) &&
                    ((in_sum & mapc_pkg::CHECK_MASK) == in_b3) &&
                    (lock_off < payload_length) &&
                    ({1'b0, lock_off} < PMAX9);

  // Sync table compare for the slot under scan
  logic          slot_hit, slot_len_match, scan_last;
  logic [SW-1:0] new_slot;

  assign slot_hit       = slot_full[scan_idx] && (slot_rd.src == src_q);
  assign slot_len_match = {1'b0, len_q} == ({1'b0, slot_rd.len} + mapc_pkg::SYNC_STEP);
  assign scan_last      = scan_idx == LAST_SLOT;
  assign new_slot       = (next_slot == LAST_SLOT) ? '0 : next_slot + SW'(1);

  always_comb begin
    slot_we = (state == ST_SLOT_CHK) && (slot_hit ? !slot_len_match : scan_last);
    slot_wa = slot_hit ? scan_idx : new_slot;
    slot_wd = '{src: src_q, dlb: b5_q, len: len_q};
  end

  // Sync table storage
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[scan_idx];
  end

  // Payload writes and CRC request
  always_comb begin
    crc_req.we    = (state == ST_WR_LO) || (state == ST_WR_HI);
    crc_req.waddr = (state == ST_WR_LO) ? off_q : off_q + 8'd1;
    crc_req.wdata = (state == ST_WR_LO) ? b4_q : b5_q;
    crc_req.start = (state == ST_WR_HI);
    crc_req.len   = payload_length;
  end

  mapc_crc_engine #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_crc (
    .clk(clk),
    .rst(rst),
    .req(crc_req),
    .rsp(crc_rsp)
  );

  assign busy = (state != ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= mapc_pkg::MODE_WAIT;
      next_slot      <= '0;
      scan_idx       <= '0;
      slot_full      <= '0;
      payload_length <= '0;
      base_length    <= '0;
      expected_crc   <= '0;
      status_valid   <= 1'b0;
      status         <= mapc_pkg::MODE_WAIT;
    end else begin
      status_valid <= 1'b0;
      if (slot_we) begin
        slot_full[slot_wa] <= (len_q != 8'd0);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            src_q <= source_address;
            len_q <= in_len;
            b4_q  <= in_b4;
            b5_q  <= in_b5;
            off_q <= lock_off;
            if (ignore) begin
              status_valid <= 1'b1;
              status       <= mapc_pkg::MODE_WAIT;
            end else if (mode == mapc_pkg::MODE_WAIT && is_sync) begin
              scan_idx <= '0;
              state    <= ST_SLOT_RD;
            end else if (mode == mapc_pkg::MODE_LOCK && lock_ok) begin
              state <= ST_WR_LO;
            end else begin
              status_valid <= 1'b1;
              status       <= mode;
            end
          end
        end
        ST_SLOT_RD: begin
          state <= ST_SLOT_CHK;
        end
        ST_SLOT_CHK: begin
          if (slot_hit) begin
            status_valid <= 1'b1;
            state        <= ST_IDLE;
            if (slot_len_match && ({1'b0, slot_rd.dlb} <= PMAX9)) begin
              expected_crc   <= b5_q;
              payload_length <= slot_rd.dlb;
              base_length    <= slot_rd.len;
              mode           <= mapc_pkg::MODE_LOCK;
              status         <= mapc_pkg::MODE_LOCK;
            end else begin
              status <= mapc_pkg::MODE_WAIT;
            end
          end else if (scan_last) begin
            next_slot    <= new_slot;
            status_valid <= 1'b1;
            status       <= mapc_pkg::MODE_WAIT;
            state        <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + SW'(1);
            state    <= ST_SLOT_RD;
          end
        end
        ST_WR_LO: begin
          state <= ST_WR_HI;
        end
        ST_WR_HI: begin
          state <= ST_CRC_WAIT;
        end
        ST_CRC_WAIT: begin
          if (crc_rsp.done) begin
            status_valid <= 1'b1;
            state        <= ST_IDLE;
            if (crc_rsp.crc == expected_crc) begin
              mode   <= mapc_pkg::MODE_DONE;
              status <= mapc_pkg::MODE_DONE;
            end else begin
              status <= mapc_pkg::MODE_LOCK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> !busy)
    else $error("result strobe while busy");

  a_ignored_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && ignore) |=> (status_valid && status == mapc_pkg::MODE_WAIT))
    else $error("ignored frame did not report waiting");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (mode == mapc_pkg::MODE_DONE) |=> (mode == mapc_pkg::MODE_DONE))
    else $error("complete mode left without reset");

  a_crc_done_expected: assert property (@(posedge clk) disable iff (rst)
    crc_rsp.done |-> (state == ST_CRC_WAIT))
    else $error("crc done outside of crc wait");

  a_write_only_locked: assert property (@(posedge clk) disable iff (rst)
    crc_req.we |-> (mode == mapc_pkg::MODE_LOCK))
    else $error("payload write while not locked");

endmodule

`default_nettype wire
